/* rtl/htw_pkg.sv */
// Shared types, codes and default sizes of the hashed timer wheel.
package htw_pkg;

   localparam int HTW_NUM_SLOTS     = 64;
   localparam int HTW_NUM_TIMERS    = 16;
   localparam int HTW_INTERVAL_BITS = 16;

   localparam int CMD_W       = 2;
   localparam int ID_W        = 4;
   localparam int STATUS_W    = 3;
   localparam int MAX_REPORTS = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_ADDED     = 3'd0,
      STAT_REMOVED   = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_EXPIRED   = 3'd3,
      STAT_NONE      = 3'd4
   } status_type;

endpackage

/* rtl/htw_if.sv */
// Command and result channel interfaces of the hashed timer wheel.
interface htw_req_if
   import htw_pkg::*;
   #(parameter int INTERVAL_BITS = HTW_INTERVAL_BITS)
   ();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic [ID_W-1:0]          timer_id;
   logic [INTERVAL_BITS-1:0] interval;

   modport source (output valid, command, timer_id, interval, input ready);
   modport sink   (input valid, command, timer_id, interval, output ready);
endinterface

interface htw_rsp_if
   import htw_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [ID_W-1:0]     timer_id_res;
   logic [STATUS_W-1:0] status;
   logic                last;

   modport source (output valid, timer_id_res, status, last, input ready);
   modport sink   (input valid, timer_id_res, status, last, output ready);
endinterface

/* rtl/htw_div.sv */
// Divider by the slot count: quotient and remainder of a period by reciprocal multiplication.
module htw_div
   import htw_pkg::*;
   #(
      parameter int NUM_SLOTS     = HTW_NUM_SLOTS,
      parameter int INTERVAL_BITS = HTW_INTERVAL_BITS
   )
   (
      input  logic                     clock,
      input  logic                     reset,
      input  logic                     start,
      input  logic [INTERVAL_BITS-1:0] dividend,
      output logic                     done,
      output logic [INTERVAL_BITS-1:0] quotient,
      output logic [$clog2(NUM_SLOTS)-1:0] remainder
   );

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int IB = INTERVAL_BITS;
   localparam int PW = 2 * IB + 1;
   localparam int SH = IB + SW;
   // ceil(2^SH / NUM_SLOTS): floor of x * RECIP >> SH is exact for every IB-bit x
   localparam logic [IB:0] RECIP =
      (IB+1)'(((64'd1 << SH) + 64'(NUM_SLOTS) - 64'd1) / 64'(NUM_SLOTS));

   logic             s1_ff;
   logic             s2_ff;
   logic             done_ff;
   logic [IB-1:0]    dvd_ff;
   logic [IB-1:0]    quo_ff;
   logic [SW-1:0]    rem_ff;

   logic [PW-1:0]    prod;
   logic [IB-1:0]    quo_in;
   logic [IB+SW-1:0] back;
   logic [SW-1:0]    rem_in;

   always_comb begin
      prod   = PW'(dvd_ff) * PW'(RECIP);
      quo_in = IB'(prod >> SH);
      back   = (IB+SW)'(quo_ff) * (IB+SW)'(NUM_SLOTS);
      rem_in = SW'((IB+SW)'(dvd_ff) - back);
   end

   // three stages: hold the dividend, form the quotient, then the remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= 1'b0;
         s2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= start;
         s2_ff   <= s1_ff;
         done_ff <= s2_ff;
         if (start) begin
            dvd_ff <= dividend;
         end
         if (s1_ff) begin
            quo_ff <= quo_in;
         end
         if (s2_ff) begin
            rem_ff <= rem_in;
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/htw_entry_mem.sv */
// Timer entry memory: one write port, one read port with registered data.
module htw_entry_mem
   #(
      parameter int DEPTH = 16,
      parameter int WIDTH = 8
   )
   (
      input  logic                                 clock,
      input  logic                                 wr_en,
      input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
      input  logic [WIDTH-1:0]                     wr_data,
      input  logic                                 rd_en,
      input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
      output logic [WIDTH-1:0]                     rd_data
   );

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/hashed_timer_wheel_core.sv */
// Top level of the hashed timer wheel: command decode, tick scan and result register.
//
// Periodic timer wheel with NUM_SLOTS slots and NUM_TIMERS timers. Each command
// item is add, remove or tick; the unused code is taken without a result.
// Remove answers in the cycle after acceptance. Add splits the period by the
// slot count with a reciprocal multiplication in the pipelined divider, and
// its result is registered once the divider is done. A tick walks the entry
// memory one timer per cycle while the result side does not hold it back,
// reading the next entry while writing back the current one. Expired timers
// come out in ascending id order; the final one is marked last once the walk
// has ended, and a tick with no expiry gives a single "nothing expired" result.
// At most MAX_REPORTS expiries are reported per tick, though all are re-armed.
// A new command is taken only when the block is idle and the result register
// is empty. Armed flags sit in flip-flops cleared by reset; the entry memory
// needs no clearing pass.
module hashed_timer_wheel_core
   import htw_pkg::*;
   #(
      parameter int NUM_SLOTS     = HTW_NUM_SLOTS,
      parameter int NUM_TIMERS    = HTW_NUM_TIMERS,
      parameter int INTERVAL_BITS = HTW_INTERVAL_BITS
   )
   (
      input logic   clock,
      input logic   reset,
      htw_req_if.sink   req,
      htw_rsp_if.source rsp
   );

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int IB = INTERVAL_BITS;
   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int RW = $clog2(MAX_REPORTS + 1);
   // entry word: {slot, rounds, reload rounds, slot offset}
   localparam int EW = 2 * SW + 2 * IB;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   state_type              state_ff;
   logic [SW-1:0]          cur_ff;
   logic [NUM_TIMERS-1:0]  armed_ff;
   logic [IW-1:0]          idx_ff;
   logic [IW-1:0]          add_idx_ff;
   logic [ID_W-1:0]        add_id_ff;
   logic                   pend_valid_ff;
   logic [ID_W-1:0]        pend_id_ff;
   logic [RW-1:0]          rep_cnt_ff;

   logic                   rsp_valid_ff;
   logic [ID_W-1:0]        rsp_id_ff;
   status_type             rsp_status_ff;
   logic                   rsp_last_ff;

   // command decode
   cmd_type                cmd;
   logic                   id_ok;
   logic [IW-1:0]          req_idx;
   logic                   req_ready;
   logic                   req_fire;
   logic [IB-1:0]          dividend;

   // divider
   logic                   div_start;
   logic                   div_done;
   logic [IB-1:0]          div_quo;
   logic [SW-1:0]          div_rem;

   // memory
   logic                   mem_wr_en;
   logic [IW-1:0]          mem_wr_addr;
   logic [EW-1:0]          mem_wr_data;
   logic                   mem_rd_en;
   logic [IW-1:0]          mem_rd_addr;
   logic [EW-1:0]          mem_rd_data;

   logic [SW-1:0]          ent_slot;
   logic [IB-1:0]          ent_rounds;
   logic [IB-1:0]          ent_reload;
   logic [SW-1:0]          ent_off;

   // scan
   logic                   can_push;
   logic                   scan_end;
   logic                   ev_hit;
   logic                   ev_expire;
   logic                   ev_report;
   logic                   ev_go;

   // result push
   logic                   push;
   logic [ID_W-1:0]        push_id;
   status_type             push_status;
   logic                   push_last;

   // slot reached from base after (off + 1) ticks, both below the slot count
   function automatic logic [SW-1:0] slot_after(input logic [SW-1:0] base,
                                                input logic [SW-1:0] off);
      logic [SW:0] sum;
      sum = {1'b0, base} + {1'b0, off} + (SW+1)'(1);
      if (sum >= (SW+1)'(NUM_SLOTS)) begin
         sum = sum - (SW+1)'(NUM_SLOTS);
      end
      return sum[SW-1:0];
   endfunction

   assign {ent_slot, ent_rounds, ent_reload, ent_off} = mem_rd_data;

   always_comb begin
      cmd       = cmd_type'(req.command);
      id_ok     = 32'(req.timer_id) < NUM_TIMERS;
      req_idx   = IW'(req.timer_id);
      // a zero interval counts as one, so period - 1 is zero in both cases
      dividend  = (req.interval == '0) ? '0 : req.interval - IB'(1);
      can_push  = !rsp_valid_ff || rsp.ready;
      req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
      req_fire  = req.valid && req_ready;
      div_start = req_fire && (cmd == CMD_ADD) && id_ok;
      scan_end  = idx_ff == IW'(NUM_TIMERS - 1);

      ev_hit    = (state_ff == ST_SCAN) && armed_ff[idx_ff] && (ent_slot == cur_ff);
      ev_expire = ev_hit && (ent_rounds == '0);
      ev_report = ev_expire && (rep_cnt_ff < RW'(MAX_REPORTS));
      // hold the walk while an earlier expiry cannot leave the pending slot
      ev_go     = (state_ff == ST_SCAN) && !(ev_report && pend_valid_ff && !can_push);

      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff;
      mem_wr_data = '0;
      if ((state_ff == ST_DIV) && div_done) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = add_idx_ff;
         mem_wr_data = {slot_after(cur_ff, div_rem), div_quo, div_quo, div_rem};
      end else if (ev_go && ev_hit) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = idx_ff;
         if (ev_expire) begin
            mem_wr_data = {slot_after(cur_ff, ent_off), ent_reload, ent_reload, ent_off};
         end else begin
            mem_wr_data = {ent_slot, ent_rounds - IB'(1), ent_reload, ent_off};
         end
      end

      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      if (req_fire && (cmd == CMD_TICK)) begin
         mem_rd_en = 1'b1;
      end else if (ev_go && !scan_end) begin
         mem_rd_en   = 1'b1;
         mem_rd_addr = idx_ff + IW'(1);
      end

      push        = 1'b0;
      push_id     = '0;
      push_status = STAT_NONE;
      push_last   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (cmd == CMD_ADD) && !id_ok) begin
               push        = 1'b1;
               push_id     = req.timer_id;
               push_status = STAT_NOT_FOUND;
            end else if (req_fire && (cmd == CMD_REMOVE)) begin
               push        = 1'b1;
               push_id     = req.timer_id;
               push_status = (id_ok && armed_ff[req_idx]) ? STAT_REMOVED : STAT_NOT_FOUND;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               push        = 1'b1;
               push_id     = add_id_ff;
               push_status = STAT_ADDED;
            end
         end
         ST_SCAN: begin
            if (ev_go && ev_report && pend_valid_ff) begin
               push        = 1'b1;
               push_id     = pend_id_ff;
               push_status = STAT_EXPIRED;
               push_last   = 1'b0;
            end
         end
         ST_FLUSH: begin
            if (can_push) begin
               push        = 1'b1;
               push_id     = pend_valid_ff ? pend_id_ff : '0;
               push_status = pend_valid_ff ? STAT_EXPIRED : STAT_NONE;
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_ff        <= '0;
         armed_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rep_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (cmd)
                     CMD_ADD: begin
                        if (id_ok) begin
                           add_idx_ff <= req_idx;
                           add_id_ff  <= req.timer_id;
                           state_ff   <= ST_DIV;
                        end
                     end
                     CMD_REMOVE: begin
                        if (id_ok) begin
                           armed_ff[req_idx] <= 1'b0;
                        end
                     end
                     CMD_TICK: begin
                        // advance the wheel, then walk every entry from id zero
                        cur_ff        <= (cur_ff == SW'(NUM_SLOTS - 1)) ?
                                         '0 : cur_ff + SW'(1);
                        idx_ff        <= '0;
                        pend_valid_ff <= 1'b0;
                        rep_cnt_ff    <= '0;
                        state_ff      <= ST_SCAN;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  armed_ff[add_idx_ff] <= 1'b1;
                  state_ff             <= ST_IDLE;
               end
            end
            ST_SCAN: begin
               if (ev_go) begin
                  if (ev_report) begin
                     pend_valid_ff <= 1'b1;
                     pend_id_ff    <= ID_W'(idx_ff);
                     rep_cnt_ff    <= rep_cnt_ff + RW'(1);
                  end
                  if (scan_end) begin
                     state_ff <= ST_FLUSH;
                  end else begin
                     idx_ff <= idx_ff + IW'(1);
                  end
               end
            end
            ST_FLUSH: begin
               if (can_push) begin
                  pend_valid_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         // result register: load on push, drop once taken
         if (push) begin
            rsp_valid_ff  <= 1'b1;
            rsp_id_ff     <= push_id;
            rsp_status_ff <= push_status;
            rsp_last_ff   <= push_last;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req.ready        = req_ready;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.timer_id_res = rsp_id_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.last         = rsp_last_ff;

   htw_div #(
      .NUM_SLOTS     (NUM_SLOTS),
      .INTERVAL_BITS (INTERVAL_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dividend),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   htw_entry_mem #(
      .DEPTH (NUM_TIMERS),
      .WIDTH (EW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

/* sim/hashed_timer_wheel_core_test.sv */
// Self-checking testbench of the hashed timer wheel: random and directed commands, scored results.
module hashed_timer_wheel_core_test;
   import htw_pkg::*;

   localparam int LAST_LATENCY = 2 * (HTW_INTERVAL_BITS + 2) + 4;

   typedef struct {
      cmd_type                      command;
      logic [ID_W-1:0]              timer_id;
      logic [HTW_INTERVAL_BITS-1:0] interval;
   } wheel_command;

   typedef struct {
      logic [ID_W-1:0] timer_id;
      status_type      status;
      logic            last;
   } wheel_report;

   logic clock;
   logic reset;

   htw_req_if #(.INTERVAL_BITS(HTW_INTERVAL_BITS)) req_ch ();
   htw_rsp_if rsp_ch ();

   hashed_timer_wheel_core #(
      .NUM_SLOTS     (HTW_NUM_SLOTS),
      .NUM_TIMERS    (HTW_NUM_TIMERS),
      .INTERVAL_BITS (HTW_INTERVAL_BITS)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   // Commands waiting to be driven, and reports the wheel still owes us.
   wheel_command cmd_queue[$];
   wheel_report  awaited_reports[$];

   int error_count   = 0;
   int random_items  = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Shadow copy of the wheel: per-timer arming and the current slot.
   logic                         timer_armed  [HTW_NUM_TIMERS];
   logic [HTW_INTERVAL_BITS-1:0] timer_period [HTW_NUM_TIMERS];
   int unsigned                  timer_slot   [HTW_NUM_TIMERS];
   int unsigned                  timer_rounds [HTW_NUM_TIMERS];
   int unsigned                  wheel_pos;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Generous watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("hashed_timer_wheel_core_test: done, errors");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // Append one report to the tail of the awaited list.
   function automatic void await_report(input wheel_report r);
      awaited_reports.insert(awaited_reports.size(), r);
   endfunction

   // Arm a timer against the current slot; an exact multiple of the slot count
   // waits no extra round.
   function automatic void arm_timer(input int id, input logic [HTW_INTERVAL_BITS-1:0] per);
      timer_period[id] = per;
      timer_slot[id]   = (wheel_pos + per) % HTW_NUM_SLOTS;
      timer_rounds[id] = (int'(per) - 1) / HTW_NUM_SLOTS;
      timer_armed[id]  = 1'b1;
   endfunction

   // Work out the reports of one accepted command and queue them in order.
   function automatic void predict_wheel(input wheel_command c);
      logic [HTW_INTERVAL_BITS-1:0] per;
      wheel_report                  rep;
      wheel_report                  held;
      bit                           have_held;
      int                           reported;
      have_held = 0;
      reported  = 0;
      case (c.command)
         CMD_ADD: begin
            // a zero period behaves as one tick
            per = (c.interval == '0) ? HTW_INTERVAL_BITS'(1) : c.interval;
            arm_timer(int'(c.timer_id), per);
            rep = '{c.timer_id, STAT_ADDED, 1'b1};
            await_report(rep);
         end
         CMD_REMOVE: begin
            if (timer_armed[c.timer_id]) begin
               timer_armed[c.timer_id] = 1'b0;
               rep = '{c.timer_id, STAT_REMOVED, 1'b1};
            end else begin
               rep = '{c.timer_id, STAT_NOT_FOUND, 1'b1};
            end
            await_report(rep);
         end
         CMD_TICK: begin
            wheel_pos = (wheel_pos + 1) % HTW_NUM_SLOTS;
            for (int i = 0; i < HTW_NUM_TIMERS; i++) begin
               if (timer_armed[i] && timer_slot[i] == wheel_pos) begin
                  if (timer_rounds[i] == 0) begin
                     arm_timer(i, timer_period[i]);
                     if (reported < MAX_REPORTS) begin
                        // hold each expiry back until we know whether it is the final one
                        if (have_held)
                           await_report(held);
                        held      = '{ID_W'(i), STAT_EXPIRED, 1'b0};
                        have_held = 1;
                        reported++;
                     end
                  end else begin
                     timer_rounds[i]--;
                  end
               end
            end
            if (have_held) begin
               held.last = 1'b1;
               await_report(held);
            end else begin
               rep = '{'0, STAT_NONE, 1'b1};
               await_report(rep);
            end
         end
         default: ;  // unused code: the wheel drops it without a report
      endcase
   endfunction

   // Sender: score each accepted command, then present the next one or idle.
   always @(posedge clock) begin : drive_commands
      wheel_command c;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            c.command  = cmd_type'(req_ch.command);
            c.timer_id = req_ch.timer_id;
            c.interval = req_ch.interval;
            predict_wheel(c);
         end
         // hold an unaccepted command; otherwise fetch a fresh one or idle
         if (!req_ch.valid || req_ch.ready) begin
            if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               c = cmd_queue.pop_front();
               req_ch.command  <= c.command;
               req_ch.timer_id <= c.timer_id;
               req_ch.interval <= c.interval;
               req_ch.valid    <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each accepted report against the oldest awaited one.
   always @(posedge clock) begin : check_reports
      wheel_report exp_rep;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_reports.size() == 0) begin
               report_mismatch($sformatf("unexpected report id %0d status %0d last %0d",
                  rsp_ch.timer_id_res, rsp_ch.status, rsp_ch.last));
            end else begin
               exp_rep = awaited_reports.pop_front();
               if (rsp_ch.timer_id_res !== exp_rep.timer_id)
                  report_mismatch($sformatf("timer id %0d, expected %0d",
                     rsp_ch.timer_id_res, exp_rep.timer_id));
               if (rsp_ch.status !== exp_rep.status)
                  report_mismatch($sformatf("status %0d, expected %s",
                     rsp_ch.status, exp_rep.status.name()));
               if (rsp_ch.last !== exp_rep.last)
                  report_mismatch($sformatf("last %0d, expected %0d",
                     rsp_ch.last, exp_rep.last));
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic queue_command(input cmd_type cmd, input int id, input int iv);
      wheel_command c;
      c.command  = cmd;
      c.timer_id = ID_W'(id);
      c.interval = HTW_INTERVAL_BITS'(iv);
      cmd_queue.insert(cmd_queue.size(), c);
      if (cmd != CMD_UNUSED)
         random_items++;
   endtask

   // Mostly short periods so that timers fire often; some exact multiples of
   // the slot count, some mid-range, and a few across the whole field.
   function automatic int pick_period();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         return $urandom_range(1, 12);
      else if (r < 75)
         return HTW_NUM_SLOTS * $urandom_range(1, 2);
      else if (r < 90)
         return $urandom_range(13, 200);
      return $urandom_range(0, (1 << HTW_INTERVAL_BITS) - 1);
   endfunction

   // Queue one random sequence: arm-and-run, a burst of timers sharing a period,
   // a few removals, or a lone noise command.
   task automatic queue_random_sequence();
      int r;
      int n;
      int base;
      int per;
      r = $urandom_range(99);
      if (r < 45) begin
         n = $urandom_range(1, 4);
         repeat (n) queue_command(CMD_ADD, $urandom_range(HTW_NUM_TIMERS - 1), pick_period());
         n = $urandom_range(1, 8);
         repeat (n) queue_command(CMD_TICK, $urandom_range(HTW_NUM_TIMERS - 1),
                                  $urandom_range(0, (1 << HTW_INTERVAL_BITS) - 1));
      end else if (r < 60) begin
         // many timers landing in one slot give long expiry bursts, up to all of them
         n    = $urandom_range(4, HTW_NUM_TIMERS);
         base = $urandom_range(HTW_NUM_TIMERS - 1);
         per  = $urandom_range(1, 3);
         for (int i = 0; i < n; i++)
            queue_command(CMD_ADD, (base + i) % HTW_NUM_TIMERS, per);
         repeat (per + 1) queue_command(CMD_TICK, 0, 0);
      end else if (r < 80) begin
         n = $urandom_range(1, 3);
         repeat (n) queue_command(CMD_REMOVE, $urandom_range(HTW_NUM_TIMERS - 1), 0);
         queue_command(CMD_TICK, 0, 0);
      end else begin
         queue_command(cmd_type'($urandom_range(3)), $urandom_range(HTW_NUM_TIMERS - 1),
                       $urandom_range(0, (1 << HTW_INTERVAL_BITS) - 1));
      end
   endtask

   // Wait until every queued command is taken and every report is in.
   task automatic wait_for_drain();
      while (cmd_queue.size() != 0 || req_ch.valid || awaited_reports.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < HTW_NUM_TIMERS; i++) begin
         timer_armed[i]  = 1'b0;
         timer_period[i] = '0;
         timer_slot[i]   = 0;
         timer_rounds[i] = 0;
      end
      wheel_pos = 0;

      // drive every input to a known value from time zero
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.command  = CMD_ADD;
      req_ch.timer_id = '0;
      req_ch.interval = '0;
      rsp_ch.ready    = 1'b0;

      // Directed opening: empty tick, stale remove, period extremes, zero period,
      // exact slot multiples, unused code, replacement and a multi-timer expiry.
      queue_command(CMD_TICK, 0, 0);
      queue_command(CMD_REMOVE, 0, 0);
      queue_command(CMD_ADD, 0, 1);
      queue_command(CMD_ADD, 15, 65535);
      queue_command(CMD_ADD, 1, 0);
      queue_command(CMD_ADD, 2, HTW_NUM_SLOTS);
      queue_command(CMD_ADD, 3, 2 * HTW_NUM_SLOTS);
      queue_command(CMD_UNUSED, 9, 16'hFFFF);
      queue_command(CMD_TICK, 0, 0);
      queue_command(CMD_ADD, 4, 16'hAAAA);
      queue_command(CMD_ADD, 5, 16'h5555);
      queue_command(CMD_REMOVE, 15, 0);
      queue_command(CMD_REMOVE, 15, 0);
      queue_command(CMD_REMOVE, 7, 0);
      queue_command(CMD_ADD, 0, 1);
      queue_command(CMD_ADD, 7, 1);
      queue_command(CMD_ADD, 14, 1);
      queue_command(CMD_TICK, 0, 0);
      queue_command(CMD_REMOVE, 4, 0);
      queue_command(CMD_REMOVE, 5, 0);
      queue_command(CMD_TICK, 0, 0);
      random_items = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Three traffic phases: slow receiver, then slow sender, then no idling.
      // Each phase ends with a full drain, so the sender pauses with nothing owed.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 32; recv_idle_pct = 77; end
            1: begin send_idle_pct = 77; recv_idle_pct = 32; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         while (random_items < (phase + 1) * 114)
            queue_random_sequence();
         wait_for_drain();
      end

      // allow any straggling report to show up before the verdict
      repeat (LAST_LATENCY) @(posedge clock);
      if (error_count == 0)
         $display("hashed_timer_wheel_core_test: done, clean");
      else
         $display("hashed_timer_wheel_core_test: done, errors");
      $finish;
   end

endmodule
